// ===== src/two_pool_descriptor_allocator_core_assert.svh =====
// Assertion macros for the two-pool descriptor allocator.
`ifndef TWO_POOL_DESCRIPTOR_ALLOCATOR_CORE_ASSERT_SVH
`define TWO_POOL_DESCRIPTOR_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication, off during reset.
`define TPDA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tpda assertion failed");

// Next-cycle implication, off during reset.
`define TPDA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tpda assertion failed");

// Next-cycle implication, checked during reset as well.
`define TPDA_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("tpda assertion failed");

`endif

// ===== src/tpda_pkg.sv =====
// Shared types, codes and widths of the two-pool descriptor allocator.
package tpda_pkg;

    localparam int SLOT_W     = 10;
    localparam int CNT_W      = 11;
    localparam int STRIDE_W   = 13;
    localparam int ADDR_W     = 48;
    localparam int PROD_W     = SLOT_W + STRIDE_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [CNT_W-1:0] MAX_SLOTS = 11'd1024;

    // Input operation codes
    localparam logic [1:0] OP_ALLOC_GEN = 2'd0;
    localparam logic [1:0] OP_ALLOC_RES = 2'd1;
    localparam logic [1:0] OP_FREE      = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_INVALID  = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_DESC   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESV_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CPU_BASE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GPU_BASE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VISIBLE    = 3'd5;

    typedef struct packed {
        logic [1:0]        op;
        logic [SLOT_W-1:0] free_index;
    } t_in_item;

    typedef struct packed {
        logic [SLOT_W-1:0] slot_index;
        logic [ADDR_W-1:0] cpu_address;
        logic [ADDR_W-1:0] gpu_address;
        logic [ADDR_W-1:0] reserved_gpu_base;
        logic [1:0]        status;
    } t_out_item;

    // Classified command between front and back
    typedef enum logic [2:0] {
        K_NOP,
        K_ALLOC_GEN,
        K_ALLOC_RES,
        K_FREE_GEN,
        K_FREE_RES,
        K_FREE_BAD
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [SLOT_W-1:0] slot;
    } t_cmd;

    // Effective configuration as seen by front and back
    typedef struct packed {
        logic [CNT_W-1:0]    total;
        logic [CNT_W-1:0]    resv;
        logic [STRIDE_W-1:0] stride;
        logic [ADDR_W-1:0]   cpu_base;
        logic [ADDR_W-1:0]   gpu_base;
        logic                visible;
        logic [ADDR_W-1:0]   resv_gpu_base;
    } t_cfg;

    typedef struct packed {
        logic busy;
        logic out_valid;
    } t_back_stat;

endpackage

// ===== src/two_pool_descriptor_allocator_core.sv =====
// Top level of the two-pool descriptor allocator: config registers and block wiring.
//
//  channel   | handshake                | payload
//  ----------+--------------------------+-------------------------------
//  request   | push / full              | i_in_item  (op, free_index)
//  result    | pop / empty              | o_out_item (slot, addresses, status)
//  config    | i_cfg_we                 | i_cfg_index, i_cfg_data
//
// In the back-end sequencer each request passes three steps: stack memory read
// and pointer update, slot times stride multiply, base add into the result register.
// The back end takes the next request only after the result is popped. A two-entry
// command queue keeps taking requests while a result waits for pop.
// Synchronous active-low reset empties both pools; the stack memories are not
// cleared and need no clearing pass. A config write to a listed index restarts both pools via r_reinit.
module two_pool_descriptor_allocator_core import tpda_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  t_in_item              i_in_item,
    output logic                  empty,
    input  logic                  pop,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

`include "two_pool_descriptor_allocator_core_assert.svh"

    logic [CNT_W-1:0]    r_num_desc;
    logic [CNT_W-1:0]    r_resv_count;
    logic [STRIDE_W-1:0] r_stride;
    logic [ADDR_W-1:0]   r_cpu_base;
    logic [ADDR_W-1:0]   r_gpu_base;
    logic                r_visible;
    logic                r_reinit;

    t_cfg       cfg;
    t_cmd       front_cmd;
    t_cmd       queue_cmd;
    logic       queue_empty;
    logic       cmd_take;
    t_back_stat back_stat;
    logic       cfg_hit;

    // Configuration registers; any listed index restarts the pools
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_desc   <= '0;
            r_resv_count <= '0;
            r_stride     <= 13'd32;
            r_cpu_base   <= '0;
            r_gpu_base   <= '0;
            r_visible    <= 1'b0;
            r_reinit     <= 1'b0;
        end else begin
            r_reinit <= i_cfg_we && cfg_hit;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_NUM_DESC:   r_num_desc   <= i_cfg_data[CNT_W-1:0];
                    CFG_RESV_COUNT: r_resv_count <= i_cfg_data[CNT_W-1:0];
                    CFG_STRIDE:     r_stride     <= i_cfg_data[STRIDE_W-1:0];
                    CFG_CPU_BASE:   r_cpu_base   <= i_cfg_data[ADDR_W-1:0];
                    CFG_GPU_BASE:   r_gpu_base   <= i_cfg_data[ADDR_W-1:0];
                    CFG_VISIBLE:    r_visible    <= i_cfg_data[0];
                    default:        r_visible    <= r_visible;
                endcase
            end
        end
    end

    assign cfg_hit = (i_cfg_index == CFG_NUM_DESC) || (i_cfg_index == CFG_RESV_COUNT)
                  || (i_cfg_index == CFG_STRIDE) || (i_cfg_index == CFG_CPU_BASE)
                  || (i_cfg_index == CFG_GPU_BASE) || (i_cfg_index == CFG_VISIBLE);

    // Effective slot ranges, clamped to the heap size
    always_comb begin
        cfg.total         = (r_num_desc > MAX_SLOTS) ? MAX_SLOTS : r_num_desc;
        cfg.resv          = (r_resv_count > cfg.total) ? cfg.total : r_resv_count;
        cfg.stride        = r_stride;
        cfg.cpu_base      = r_cpu_base;
        cfg.gpu_base      = r_gpu_base;
        cfg.visible       = r_visible;
        cfg.resv_gpu_base = ((r_resv_count != '0) && r_visible) ? r_gpu_base : '0;
    end

    tpda_front u_front (
        .i_item (i_in_item),
        .i_cfg  (cfg),
        .o_cmd  (front_cmd)
    );

    tpda_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (cmd_take),
        .o_cmd   (queue_cmd),
        .o_empty (queue_empty)
    );

    tpda_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_reinit    (r_reinit),
        .i_cmd       (queue_cmd),
        .i_cmd_avail (!queue_empty),
        .o_cmd_take  (cmd_take),
        .i_out_pop   (pop),
        .o_out_item  (o_out_item),
        .o_stat      (back_stat)
    );

    assign empty = !back_stat.out_valid;

    // A failed result (status other than OK) never carries an address
    `TPDA_ASSERT_IMPL(a_no_addr_on_error, i_clk, i_rst_n, !empty && (o_out_item.status != ST_OK), (o_out_item.cpu_address == '0) && (o_out_item.gpu_address == '0))
    // An accepted request is queued or already in the back end
    `TPDA_ASSERT_NEXT(a_push_lands, i_clk, i_rst_n, push && !full, !queue_empty || back_stat.busy)
    // Reset leaves both sides empty
    `TPDA_ASSERT_NEXT_ALWAYS(a_reset_clean, i_clk, !i_rst_n, empty && !full && queue_empty)

endmodule

// ===== src/tpda_front.sv =====
// Front end: classifies an incoming request against the slot ranges.
module tpda_front import tpda_pkg::*; (
    input  t_in_item i_item,
    input  t_cfg     i_cfg,
    output t_cmd     o_cmd
);

    logic [CNT_W-1:0] idx_ext;

    assign idx_ext = {1'b0, i_item.free_index};

    // Pick the command kind; frees are routed to the pool that owns the slot
    always_comb begin
        o_cmd.slot = i_item.free_index;
        case (i_item.op)
            OP_ALLOC_GEN: begin
                o_cmd.kind = K_ALLOC_GEN;
            end
            OP_ALLOC_RES: begin
                o_cmd.kind = K_ALLOC_RES;
            end
            OP_FREE: begin
                if (idx_ext >= i_cfg.total) begin
                    o_cmd.kind = K_FREE_BAD;
                end else if (idx_ext < i_cfg.resv) begin
                    o_cmd.kind = K_FREE_RES;
                end else begin
                    o_cmd.kind = K_FREE_GEN;
                end
            end
            default: begin
                o_cmd.kind = K_NOP;
            end
        endcase
    end

endmodule

// ===== src/tpda_cmd_queue.sv =====
// Two-entry command queue between front and back.
module tpda_cmd_queue import tpda_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty
);

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign o_full  = r_count == 2'd2;
    assign o_empty = r_count == 2'd0;
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== src/tpda_back.sv =====
// Back end: free-list stacks, fresh counters, address math and result register.
module tpda_back import tpda_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_reinit,
    input  t_cmd       i_cmd,
    input  logic       i_cmd_avail,
    output logic       o_cmd_take,
    input  logic       i_out_pop,
    output t_out_item  o_out_item,
    output t_back_stat o_stat
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_ADD
    } t_state;

    t_state r_state;

    // Stack memories and their read registers
    logic [SLOT_W-1:0] gen_mem [MAX_SLOTS];
    logic [SLOT_W-1:0] res_mem [MAX_SLOTS];
    logic [SLOT_W-1:0] r_gen_rdata;
    logic [SLOT_W-1:0] r_res_rdata;

    // Pool pointers
    logic [CNT_W-1:0] r_gen_cnt;
    logic [CNT_W-1:0] r_res_cnt;
    logic [CNT_W-1:0] r_gen_fresh;
    logic [CNT_W-1:0] r_res_fresh;
    logic [CNT_W-1:0] n_gen_cnt;
    logic [CNT_W-1:0] n_res_cnt;
    logic [CNT_W-1:0] n_gen_fresh;
    logic [CNT_W-1:0] n_res_fresh;
    logic [CNT_W-1:0] gen_cnt_m1;
    logic [CNT_W-1:0] res_cnt_m1;

    logic gen_rd;
    logic res_rd;
    logic gen_wr;
    logic res_wr;
    logic gen_fresh_take;
    logic res_fresh_take;

    // Per-item working registers
    logic              r_out_valid;
    logic [SLOT_W-1:0] r_slot;
    logic              r_from_mem;
    logic              r_pool_res;
    logic              r_ok;
    logic [1:0]        r_status;
    logic [PROD_W-1:0] r_prod;
    t_out_item         r_out_item;

    logic [SLOT_W-1:0] c_slot;
    logic              c_ok;
    logic [1:0]        c_status;
    logic [SLOT_W-1:0] slot_sel;

    assign o_cmd_take = (r_state == S_IDLE) && i_cmd_avail && !r_out_valid && !i_reinit;

    assign gen_cnt_m1 = r_gen_cnt - 11'd1;
    assign res_cnt_m1 = r_res_cnt - 11'd1;

    // Stack and fresh-slot decisions for the command being taken
    assign gen_rd = o_cmd_take && (i_cmd.kind == K_ALLOC_GEN) && (r_gen_cnt != '0);
    assign res_rd = o_cmd_take && (i_cmd.kind == K_ALLOC_RES) && (r_res_cnt != '0);
    assign gen_fresh_take = o_cmd_take && (i_cmd.kind == K_ALLOC_GEN) && (r_gen_cnt == '0)
                            && (r_gen_fresh < i_cfg.total);
    assign res_fresh_take = o_cmd_take && (i_cmd.kind == K_ALLOC_RES) && (r_res_cnt == '0)
                            && (r_res_fresh < i_cfg.resv);
    assign gen_wr = o_cmd_take && (i_cmd.kind == K_FREE_GEN) && (r_gen_cnt != MAX_SLOTS);
    assign res_wr = o_cmd_take && (i_cmd.kind == K_FREE_RES) && (r_res_cnt != MAX_SLOTS);

    // Next pool pointers; a configuration write restarts both pools
    always_comb begin
        n_gen_cnt   = r_gen_cnt;
        n_res_cnt   = r_res_cnt;
        n_gen_fresh = r_gen_fresh;
        n_res_fresh = r_res_fresh;
        if (i_reinit) begin
            n_gen_cnt   = '0;
            n_res_cnt   = '0;
            n_gen_fresh = i_cfg.resv;
            n_res_fresh = '0;
        end else begin
            if (gen_rd) begin
                n_gen_cnt = gen_cnt_m1;
            end else if (gen_wr) begin
                n_gen_cnt = r_gen_cnt + 11'd1;
            end
            if (res_rd) begin
                n_res_cnt = res_cnt_m1;
            end else if (res_wr) begin
                n_res_cnt = r_res_cnt + 11'd1;
            end
            if (gen_fresh_take) begin
                n_gen_fresh = r_gen_fresh + 11'd1;
            end
            if (res_fresh_take) begin
                n_res_fresh = r_res_fresh + 11'd1;
            end
        end
    end

    // Slot, address enable and status of the command being taken
    always_comb begin
        c_slot   = '0;
        c_ok     = 1'b0;
        c_status = ST_OK;
        case (i_cmd.kind)
            K_ALLOC_GEN: begin
                if (r_gen_cnt != '0) begin
                    c_ok = 1'b1;
                end else if (r_gen_fresh < i_cfg.total) begin
                    c_ok   = 1'b1;
                    c_slot = r_gen_fresh[SLOT_W-1:0];
                end else begin
                    c_status = ST_EMPTY;
                end
            end
            K_ALLOC_RES: begin
                if (r_res_cnt != '0) begin
                    c_ok = 1'b1;
                end else if (r_res_fresh < i_cfg.resv) begin
                    c_ok   = 1'b1;
                    c_slot = r_res_fresh[SLOT_W-1:0];
                end else begin
                    c_status = ST_EMPTY;
                end
            end
            K_FREE_GEN: begin
                c_slot   = i_cmd.slot;
                c_status = (r_gen_cnt == MAX_SLOTS) ? ST_OVERFLOW : ST_OK;
            end
            K_FREE_RES: begin
                c_slot   = i_cmd.slot;
                c_status = (r_res_cnt == MAX_SLOTS) ? ST_OVERFLOW : ST_OK;
            end
            K_FREE_BAD: begin
                c_slot   = i_cmd.slot;
                c_status = ST_INVALID;
            end
            default: begin
                c_slot = '0;
            end
        endcase
    end

    // General stack memory
    always_ff @(posedge i_clk) begin
        if (gen_wr) begin
            gen_mem[r_gen_cnt[SLOT_W-1:0]] <= i_cmd.slot;
        end
        if (gen_rd) begin
            r_gen_rdata <= gen_mem[gen_cnt_m1[SLOT_W-1:0]];
        end
    end

    // Reserved stack memory
    always_ff @(posedge i_clk) begin
        if (res_wr) begin
            res_mem[r_res_cnt[SLOT_W-1:0]] <= i_cmd.slot;
        end
        if (res_rd) begin
            r_res_rdata <= res_mem[res_cnt_m1[SLOT_W-1:0]];
        end
    end

    // Sequencer state, result valid and pool pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_gen_cnt   <= '0;
            r_res_cnt   <= '0;
            r_gen_fresh <= '0;
            r_res_fresh <= '0;
        end else begin
            r_gen_cnt   <= n_gen_cnt;
            r_res_cnt   <= n_res_cnt;
            r_gen_fresh <= n_gen_fresh;
            r_res_fresh <= n_res_fresh;
            case (r_state)
                S_IDLE: begin
                    if (o_cmd_take) begin
                        r_state <= S_MUL;
                    end
                    if (r_out_valid && i_out_pop) begin
                        r_out_valid <= 1'b0;
                    end
                end
                S_MUL: begin
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_state     <= S_IDLE;
                    r_out_valid <= 1'b1;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign slot_sel = !r_from_mem ? r_slot : (r_pool_res ? r_res_rdata : r_gen_rdata);

    // Datapath: capture command, multiply slot by stride, then add bases
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (o_cmd_take) begin
                    r_slot     <= c_slot;
                    r_from_mem <= gen_rd || res_rd;
                    r_pool_res <= i_cmd.kind == K_ALLOC_RES;
                    r_ok       <= c_ok;
                    r_status   <= c_status;
                end
            end
            S_MUL: begin
                r_slot <= slot_sel;
                r_prod <= PROD_W'(slot_sel) * PROD_W'(i_cfg.stride);
            end
            S_ADD: begin
                r_out_item.slot_index  <= r_slot;
                r_out_item.cpu_address <= r_ok
                    ? i_cfg.cpu_base + ADDR_W'(r_prod) : '0;
                r_out_item.gpu_address <= (r_ok && i_cfg.visible)
                    ? i_cfg.gpu_base + ADDR_W'(r_prod) : '0;
                r_out_item.reserved_gpu_base <= i_cfg.resv_gpu_base;
                r_out_item.status            <= r_status;
            end
            default: begin
                r_slot <= r_slot;
            end
        endcase
    end

    assign o_out_item       = r_out_item;
    assign o_stat.busy      = r_state != S_IDLE;
    assign o_stat.out_valid = r_out_valid;

endmodule
